[rtl/isterr_pkg.sv]
// shared constants and types for the inductor steering error block
`timescale 1ns / 1ps

package isterr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 13;
    localparam int GAIN_W          = 12;
    localparam int OFFSET_W        = 11;
    localparam int MLT_W           = 12;
    localparam int SST_W           = 13;
    localparam int MARGIN_W        = 12;
    localparam int EDGE_W          = 9;
    localparam int ERR_W           = 11;
    localparam int QBITS           = 7;
    localparam int RATIO_W         = QBITS + 1;
    localparam int NDIV            = 4;
    localparam int FIFO_DEPTH      = 2;

    localparam int SUM_W           = 14;
    localparam int MAG_W           = SUM_W - 1;
    localparam int RECIP7_W        = 14;
    localparam int RECIP7_SHIFT    = 16;
    localparam logic [RECIP7_W-1:0] RECIP7 = 14'd9363;
    localparam int PROD7_W         = MAG_W + RECIP7_W;

    localparam logic signed [ERR_W:0] MEET_BIAS = 12'sd5;
    localparam logic signed [ERR_W:0] ERR_MAX   = 12'sd1023;
    localparam logic signed [ERR_W:0] ERR_MIN   = -12'sd1024;

    localparam logic signed [GAIN_W-1:0]   RST_GAIN   = 12'sd256;
    localparam logic signed [OFFSET_W-1:0] RST_OFFSET = 11'sd0;
    localparam logic [MLT_W-1:0]           RST_MLT    = 12'd500;
    localparam logic [SST_W-1:0]           RST_SST    = 13'd800;
    localparam logic [MARGIN_W-1:0]        RST_MARGIN = 12'd50;
    localparam logic [EDGE_W-1:0]          RST_EDGE   = 9'd40;

    // divider lanes
    localparam int LANE_LR   = 0;
    localparam int LANE_LM   = 1;
    localparam int LANE_RM   = 2;
    localparam int LANE_MEET = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_GAIN   = 3'd0,
        CFG_RIGHT_OFFSET = 3'd1,
        CFG_LEFT_GAIN    = 3'd2,
        CFG_LEFT_OFFSET  = 3'd3,
        CFG_MIDDLE_LOW   = 3'd4,
        CFG_SIDE_SUM     = 3'd5,
        CFG_SIDE_MARGIN  = 3'd6,
        CFG_EDGE_ERROR   = 3'd7
    } t_cfg_idx;

endpackage

[rtl/isterr_front.sv]
// front end: forms dividends, divisors and edge override flags per sample
`timescale 1ns / 1ps

module isterr_front #(
    parameter int SAMPLE_BITS = isterr_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]            i_left,
    input  logic [SAMPLE_BITS-1:0]            i_right,
    input  logic [SAMPLE_BITS-1:0]            i_middle,
    input  logic                              i_meet,
    input  logic [isterr_pkg::MLT_W-1:0]      i_mlt,
    input  logic [isterr_pkg::SST_W-1:0]      i_sst,
    input  logic [isterr_pkg::MARGIN_W-1:0]   i_margin,
    output logic [4*(2*SAMPLE_BITS+11)+10:0]  o_entry
);
    localparam int S  = SAMPLE_BITS;
    localparam int NW = S + 2;
    localparam int DW = S + 9;
    localparam int FB = 4 * (DW + NW);
    localparam int CW = S + 14;

    logic signed [S+2:0] d   [isterr_pkg::NDIV];
    logic [NW-1:0]       den [isterr_pkg::NDIV];
    logic [NW-1:0]       mag [isterr_pkg::NDIV];
    logic [DW-1:0]       dvd [isterr_pkg::NDIV];
    logic                neg [isterr_pkg::NDIV];
    logic [CW-1:0]       l_x, r_x, m_x;
    logic                near_edge;
    logic                force_pos;
    logic                force_neg;

    always_comb begin
        d[isterr_pkg::LANE_LR]     = $signed({3'b0, i_right}) - $signed({3'b0, i_left});
        den[isterr_pkg::LANE_LR]   = {2'b0, i_left} + {2'b0, i_right};
        d[isterr_pkg::LANE_LM]     = $signed({3'b0, i_left}) - $signed({3'b0, i_middle});
        den[isterr_pkg::LANE_LM]   = {2'b0, i_left} + {2'b0, i_middle};
        d[isterr_pkg::LANE_RM]     = $signed({3'b0, i_right}) - $signed({3'b0, i_middle});
        den[isterr_pkg::LANE_RM]   = {2'b0, i_right} + {2'b0, i_middle};
        d[isterr_pkg::LANE_MEET]   = $signed({2'b0, i_middle, 1'b0}) - $signed({3'b0, i_left});
        den[isterr_pkg::LANE_MEET] = {2'b0, i_left} + {1'b0, i_middle, 1'b0};
        for (int i = 0; i < isterr_pkg::NDIV; i++) begin
            neg[i] = d[i][S+2];
            mag[i] = neg[i] ? NW'(-d[i]) : NW'(d[i]);
            // times 100
            dvd[i] = ({7'b0, mag[i]} << 6) + ({7'b0, mag[i]} << 5) + ({7'b0, mag[i]} << 2);
        end
    end

    always_comb begin
        l_x       = CW'(i_left);
        r_x       = CW'(i_right);
        m_x       = CW'(i_middle);
        near_edge = (m_x < CW'(i_mlt)) && ((l_x + r_x) < CW'(i_sst));
        force_pos = near_edge && (r_x > l_x + CW'(i_margin));
        force_neg = near_edge && !force_pos && (l_x > r_x + CW'(i_margin));
    end

    always_comb begin
        for (int i = 0; i < isterr_pkg::NDIV; i++) begin
            o_entry[i*DW +: DW]          = dvd[i];
            o_entry[4*DW + i*NW +: NW]   = den[i];
            o_entry[FB + i]              = neg[i];
            o_entry[FB + 4 + i]          = (den[i] == '0);
        end
        o_entry[FB + 8]  = i_meet;
        o_entry[FB + 9]  = force_pos;
        o_entry[FB + 10] = force_neg;
    end

endmodule

[rtl/isterr_fifo.sv]
// short queue between front and back ends
`timescale 1ns / 1ps

module isterr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = isterr_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[rtl/isterr_back.sv]
// back end: pipelined ratio dividers, gain and offset, blend, override, saturation
`timescale 1ns / 1ps

module isterr_back #(
    parameter int SAMPLE_BITS = isterr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_nonempty,
    input  logic [4*(2*SAMPLE_BITS+11)+10:0]        i_entry,
    output logic                                    o_pop,
    input  logic signed [isterr_pkg::GAIN_W-1:0]    i_right_gain,
    input  logic signed [isterr_pkg::OFFSET_W-1:0]  i_right_offset,
    input  logic signed [isterr_pkg::GAIN_W-1:0]    i_left_gain,
    input  logic signed [isterr_pkg::OFFSET_W-1:0]  i_left_offset,
    input  logic [isterr_pkg::EDGE_W-1:0]           i_edge_error,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [isterr_pkg::ERR_W-1:0]     o_steer_error
);
    localparam int S   = SAMPLE_BITS;
    localparam int NW  = S + 2;
    localparam int DW  = S + 9;
    localparam int FB  = 4 * (DW + NW);
    localparam int Q   = isterr_pkg::QBITS;
    localparam int ND  = isterr_pkg::NDIV;
    localparam int RW  = isterr_pkg::RATIO_W;
    localparam int GW  = isterr_pkg::GAIN_W;
    localparam int PW  = GW + RW;
    localparam int TW  = PW - 8;
    localparam int SW  = isterr_pkg::SUM_W;
    localparam int MW  = isterr_pkg::MAG_W;
    localparam int EW  = isterr_pkg::ERR_W;
    localparam int XW  = isterr_pkg::PROD7_W;
    localparam int MET = 11;

    logic en;

    // divider stages
    logic          r_v    [Q+1];
    logic [DW-1:0] r_rem  [Q+1][ND];
    logic [NW-1:0] r_den  [Q+1][ND];
    logic [Q-1:0]  r_q    [Q+1][ND];
    logic [MET-1:0] r_meta [Q+1];

    assign en    = !o_valid || !i_stall;
    assign o_pop = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < ND; i++) begin
                r_rem[0][i] <= i_entry[i*DW +: DW];
                r_den[0][i] <= i_entry[4*DW + i*NW +: NW];
                r_q[0][i]   <= '0;
            end
            r_meta[0] <= i_entry[FB +: MET];
        end
    end

    genvar k;
    generate
        for (k = 1; k <= Q; k++) begin : g_div
            logic [DW-1:0] trial [ND];
            logic          ge    [ND];

            always_comb begin
                for (int i = 0; i < ND; i++) begin
                    trial[i] = DW'(r_den[k-1][i]) << (Q - k);
                    ge[i]    = (r_rem[k-1][i] >= trial[i]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en) begin
                    r_v[k] <= r_v[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    for (int i = 0; i < ND; i++) begin
                        r_rem[k][i] <= ge[i] ? r_rem[k-1][i] - trial[i] : r_rem[k-1][i];
                        r_den[k][i] <= r_den[k-1][i];
                        r_q[k][i]   <= {r_q[k-1][i][Q-2:0], ge[i]};
                    end
                    r_meta[k] <= r_meta[k-1];
                end
            end
        end
    endgenerate

    // signed ratios and gain products
    logic signed [RW-1:0] ratio [ND];
    logic                 r_a_v;
    logic signed [RW-1:0] r_a_lr, r_a_mt;
    logic signed [PW-1:0] r_a_pl, r_a_pr;
    logic [2:0]           r_a_fl;

    always_comb begin
        for (int i = 0; i < ND; i++) begin
            if (r_meta[Q][4 + i]) begin
                ratio[i] = '0;
            end else if (r_meta[Q][i]) begin
                ratio[i] = -$signed({1'b0, r_q[Q][i]});
            end else begin
                ratio[i] = $signed({1'b0, r_q[Q][i]});
            end
        end
    end

    // blend sum
    logic signed [TW-1:0] lm_t, rm_t;
    logic signed [SW-1:0] lm_s, rm_s, n_sum;
    logic                 r_b_v;
    logic signed [SW-1:0] r_b_sum;
    logic signed [RW-1:0] r_b_mt;
    logic [2:0]           r_b_fl;

    always_comb begin
        lm_t  = TW'((r_a_pl + (r_a_pl[PW-1] ? PW'(255) : PW'(0))) >>> 8);
        rm_t  = TW'((r_a_pr + (r_a_pr[PW-1] ? PW'(255) : PW'(0))) >>> 8);
        lm_s  = SW'(lm_t) + SW'(i_left_offset);
        rm_s  = SW'(rm_t) + SW'(i_right_offset);
        n_sum = (SW'(r_a_lr) <<< 2) + SW'(r_a_lr) + lm_s + rm_s;
    end

    // divide by seven
    logic [MW-1:0]        sum_mag;
    logic                 r_c_v, r_c_neg;
    logic [XW-1:0]        r_c_prod;
    logic signed [RW-1:0] r_c_mt;
    logic [2:0]           r_c_fl;

    assign sum_mag = r_b_sum[SW-1] ? MW'(-r_b_sum) : MW'(r_b_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= r_v[Q];
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_lr   <= ratio[isterr_pkg::LANE_LR];
            r_a_mt   <= ratio[isterr_pkg::LANE_MEET];
            r_a_pl   <= PW'(i_left_gain) * PW'(ratio[isterr_pkg::LANE_LM]);
            r_a_pr   <= PW'(i_right_gain) * PW'(ratio[isterr_pkg::LANE_RM]);
            r_a_fl   <= r_meta[Q][10:8];
            r_b_sum  <= n_sum;
            r_b_mt   <= r_a_mt;
            r_b_fl   <= r_a_fl;
            r_c_prod <= XW'(sum_mag) * XW'(isterr_pkg::RECIP7);
            r_c_neg  <= r_b_sum[SW-1];
            r_c_mt   <= r_b_mt;
            r_c_fl   <= r_b_fl;
        end
    end

    // final select and saturation
    logic [EW-1:0]        quo7;
    logic signed [EW:0]   n_err;

    always_comb begin
        quo7 = r_c_prod[isterr_pkg::RECIP7_SHIFT +: EW];
        if (r_c_fl[1]) begin
            n_err = $signed({3'b0, i_edge_error});
        end else if (r_c_fl[2]) begin
            n_err = -$signed({3'b0, i_edge_error});
        end else if (r_c_fl[0]) begin
            n_err = (EW+1)'(r_c_mt) + isterr_pkg::MEET_BIAS;
        end else if (r_c_neg) begin
            n_err = -$signed({1'b0, quo7});
        end else begin
            n_err = $signed({1'b0, quo7});
        end
        if (n_err > isterr_pkg::ERR_MAX) begin
            n_err = isterr_pkg::ERR_MAX;
        end else if (n_err < isterr_pkg::ERR_MIN) begin
            n_err = isterr_pkg::ERR_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c_v) begin
            o_steer_error <= EW'(n_err);
        end
    end

endmodule

[rtl/inductor_steering_error_core.sv]
// top level of the inductor steering error block
//
// one input transfer (left, right, middle readings and meeting mode) gives
// one output transfer carrying the signed steering error
// both channels use valid and stall; a transfer happens when valid is high
// and stall is low; o_stall is raised only when the two-entry queue is full
// throughput is one sample per cycle while the output is not stalled
// from input transfer to o_valid a sample passes through the queue,
// divider load, a seven-stage restoring divider (one quotient bit per stage
// for the four ratios in parallel), gain multiply, blend sum, reciprocal
// multiply for the divide by seven, and the output register
// when i_stall holds the output, the whole back pipe holds and the queue
// absorbs up to two further samples before o_stall rises
// synchronous active-low reset empties the queue and pipe and loads the
// configuration registers with their defaults
// configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must make them only while no sample is in flight, as the block does not enforce it
`timescale 1ns / 1ps

module inductor_steering_error_core #(
    parameter int SAMPLE_BITS = isterr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [SAMPLE_BITS-1:0]                  i_left_reading,
    input  logic [SAMPLE_BITS-1:0]                  i_right_reading,
    input  logic [SAMPLE_BITS-1:0]                  i_middle_reading,
    input  logic                                    i_meeting_mode,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [isterr_pkg::ERR_W-1:0]     o_steer_error,
    input  logic                                    i_cfg_we,
    input  logic [isterr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [isterr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int EW = 4 * (2 * SAMPLE_BITS + 11) + 11;

    logic signed [isterr_pkg::GAIN_W-1:0]   r_right_gain, r_left_gain;
    logic signed [isterr_pkg::OFFSET_W-1:0] r_right_offset, r_left_offset;
    logic [isterr_pkg::MLT_W-1:0]           r_mlt;
    logic [isterr_pkg::SST_W-1:0]           r_sst;
    logic [isterr_pkg::MARGIN_W-1:0]        r_margin;
    logic [isterr_pkg::EDGE_W-1:0]          r_edge;

    logic [EW-1:0] front_entry, queue_entry;
    logic          queue_full, queue_nonempty, queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_gain   <= isterr_pkg::RST_GAIN;
            r_right_offset <= isterr_pkg::RST_OFFSET;
            r_left_gain    <= isterr_pkg::RST_GAIN;
            r_left_offset  <= isterr_pkg::RST_OFFSET;
            r_mlt          <= isterr_pkg::RST_MLT;
            r_sst          <= isterr_pkg::RST_SST;
            r_margin       <= isterr_pkg::RST_MARGIN;
            r_edge         <= isterr_pkg::RST_EDGE;
        end else if (i_cfg_we) begin
            unique case (isterr_pkg::t_cfg_idx'(i_cfg_idx))
                isterr_pkg::CFG_RIGHT_GAIN:   r_right_gain   <= i_cfg_data[11:0];
                isterr_pkg::CFG_RIGHT_OFFSET: r_right_offset <= i_cfg_data[10:0];
                isterr_pkg::CFG_LEFT_GAIN:    r_left_gain    <= i_cfg_data[11:0];
                isterr_pkg::CFG_LEFT_OFFSET:  r_left_offset  <= i_cfg_data[10:0];
                isterr_pkg::CFG_MIDDLE_LOW:   r_mlt          <= i_cfg_data[11:0];
                isterr_pkg::CFG_SIDE_SUM:     r_sst          <= i_cfg_data[12:0];
                isterr_pkg::CFG_SIDE_MARGIN:  r_margin       <= i_cfg_data[11:0];
                isterr_pkg::CFG_EDGE_ERROR:   r_edge         <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    isterr_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_left   (i_left_reading),
        .i_right  (i_right_reading),
        .i_middle (i_middle_reading),
        .i_meet   (i_meeting_mode),
        .i_mlt    (r_mlt),
        .i_sst    (r_sst),
        .i_margin (r_margin),
        .o_entry  (front_entry)
    );

    assign o_stall = queue_full;

    isterr_fifo #(
        .WIDTH(EW)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_data     (front_entry),
        .o_full     (queue_full),
        .i_pop      (queue_pop),
        .o_nonempty (queue_nonempty),
        .o_data     (queue_entry)
    );

    isterr_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (queue_nonempty),
        .i_entry        (queue_entry),
        .o_pop          (queue_pop),
        .i_right_gain   (r_right_gain),
        .i_right_offset (r_right_offset),
        .i_left_gain    (r_left_gain),
        .i_left_offset  (r_left_offset),
        .i_edge_error   (r_edge),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_steer_error  (o_steer_error)
    );

endmodule

[rtl/isterr_checker.sv]
// port-level checks for the inductor steering error block
`timescale 1ns / 1ps

module isterr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [isterr_pkg::ERR_W-1:0]  o_steer_error
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall set after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_steer_error))
        else $error("stalled output transfer changed");

    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(!i_stall) |-> !o_stall)
        else $error("input stalled although output was free");

endmodule

bind inductor_steering_error_core isterr_checker u_isterr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_steer_error (o_steer_error)
);

[verif/inductor_steering_error_checker.sv]
// checker that predicts and compares the steering error of each sample
`timescale 1ns / 1ps

module inductor_steering_error_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic [11:0]                         i_left_reading,
    input  logic [11:0]                         i_right_reading,
    input  logic [11:0]                         i_middle_reading,
    input  logic                                i_meeting_mode,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [isterr_pkg::ERR_W-1:0] o_steer_error,
    input  logic                                i_cfg_we,
    input  logic [isterr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [isterr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_results_seen
);
    int right_gain, right_offset, left_gain, left_offset;
    int middle_low, side_sum, side_margin, edge_err;
    logic signed [isterr_pkg::ERR_W-1:0] error_queue[$];

    function automatic int pct_ratio(int num, int den);
        if (den == 0) return 0;
        return (100 * num) / den;
    endfunction

    function automatic logic signed [isterr_pkg::ERR_W-1:0] steer_predict(int l, int r,
                                                                           int m, bit meet);
        int lr, lm, rm, err;
        lr = pct_ratio(r - l, l + r);
        lm = (left_gain * pct_ratio(l - m, l + m)) / 256 + left_offset;
        rm = (right_gain * pct_ratio(r - m, r + m)) / 256 + right_offset;
        err = (5 * lr + lm + rm) / 7;
        if (meet) err = pct_ratio(2 * m - l, l + 2 * m) + 5;
        if (m < middle_low && l + r < side_sum) begin
            if (r > l + side_margin) err = edge_err;
            else if (l > r + side_margin) err = -edge_err;
        end
        if (err > 1023) err = 1023;
        if (err < -1024) err = -1024;
        return err[isterr_pkg::ERR_W-1:0];
    endfunction

    assign o_pending = error_queue.size();

    always @(posedge i_clk) begin
        logic signed [isterr_pkg::ERR_W-1:0] want;
        if (!i_rst_n) begin
            right_gain <= 256; right_offset <= 0; left_gain <= 256; left_offset <= 0;
            middle_low <= 500; side_sum <= 800; side_margin <= 50; edge_err <= 40;
            error_queue.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (isterr_pkg::t_cfg_idx'(i_cfg_idx))
                    isterr_pkg::CFG_RIGHT_GAIN:   right_gain   <= $signed(i_cfg_data[11:0]);
                    isterr_pkg::CFG_RIGHT_OFFSET: right_offset <= $signed(i_cfg_data[10:0]);
                    isterr_pkg::CFG_LEFT_GAIN:    left_gain    <= $signed(i_cfg_data[11:0]);
                    isterr_pkg::CFG_LEFT_OFFSET:  left_offset  <= $signed(i_cfg_data[10:0]);
                    isterr_pkg::CFG_MIDDLE_LOW:   middle_low   <= i_cfg_data[11:0];
                    isterr_pkg::CFG_SIDE_SUM:     side_sum     <= i_cfg_data[12:0];
                    isterr_pkg::CFG_SIDE_MARGIN:  side_margin  <= i_cfg_data[11:0];
                    isterr_pkg::CFG_EDGE_ERROR:   edge_err     <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                error_queue.push_back(steer_predict(i_left_reading, i_right_reading,
                    i_middle_reading, i_meeting_mode));
            if (o_valid && !i_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (error_queue.size() == 0) begin
                    $error("unexpected transfer steer_error=%0d", o_steer_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = error_queue.pop_front();
                    if (want !== o_steer_error) begin
                        $error("steer_error expected %0d actual %0d", want, o_steer_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/inductor_steering_error_core_test.sv]
// stimulus and verdict for the inductor steering error block
`timescale 1ns / 1ps

module inductor_steering_error_core_test;
    logic i_clk, i_rst_n, i_valid, o_stall, i_meeting_mode, o_valid, i_stall, i_cfg_we;
    logic [11:0] i_left_reading, i_right_reading, i_middle_reading;
    logic signed [isterr_pkg::ERR_W-1:0] o_steer_error;
    logic [isterr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [isterr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    int fail_count, pending, results_seen, idle_cycles, samples_sent;
    bit timed_out;

    inductor_steering_error_core uut (.*);

    inductor_steering_error_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_left_reading, .i_right_reading,
        .i_middle_reading, .i_meeting_mode, .o_valid, .i_stall, .o_steer_error,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_fail_count(fail_count),
        .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall, with long quiet stretches
    initial begin
        int g;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            g = gap_len();
            if (g > 0 && $urandom_range(0, 3) != 0) begin
                i_stall <= 1;
                repeat (g) @(posedge i_clk);
                i_stall <= 0;
            end else begin
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        timed_out = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("inductor_steering_error_core test failed");
                $finish;
            end
        end
    end

    task automatic send_sample(int l, int r, int m, bit meet, bit allow_gap);
        int g;
        if (allow_gap) begin
            g = gap_len();
            if (g > 0) begin
                i_valid <= 0;
                repeat (g) @(posedge i_clk);
            end
        end
        i_valid <= 1;
        i_left_reading <= l[11:0];
        i_right_reading <= r[11:0];
        i_middle_reading <= m[11:0];
        i_meeting_mode <= meet;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(isterr_pkg::t_cfg_idx idx, int value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[isterr_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic load_settings(int rg, int ro, int lg, int lo, int ml, int ss, int sm, int ee);
        write_reg(isterr_pkg::CFG_RIGHT_GAIN, rg);
        write_reg(isterr_pkg::CFG_RIGHT_OFFSET, ro);
        write_reg(isterr_pkg::CFG_LEFT_GAIN, lg);
        write_reg(isterr_pkg::CFG_LEFT_OFFSET, lo);
        write_reg(isterr_pkg::CFG_MIDDLE_LOW, ml);
        write_reg(isterr_pkg::CFG_SIDE_SUM, ss);
        write_reg(isterr_pkg::CFG_SIDE_MARGIN, sm);
        write_reg(isterr_pkg::CFG_EDGE_ERROR, ee);
        @(posedge i_clk);
    endtask

    function automatic int rand_reading();
        int p = $urandom_range(0, 9);
        if (p < 2) return $urandom_range(0, 4);
        if (p < 4) return $urandom_range(4091, 4095);
        if (p < 6) return $urandom_range(0, 600);
        return $urandom_range(0, 4095);
    endfunction

    task automatic random_phase(int count);
        int l, r, m;
        repeat (count) begin
            l = rand_reading();
            r = rand_reading();
            m = rand_reading();
            if ($urandom_range(0, 3) == 0) begin
                // near an edge: weak middle and small sides
                l = $urandom_range(0, 700);
                r = $urandom_range(0, 700);
                m = $urandom_range(0, 600);
            end
            send_sample(l, r, m, $urandom_range(0, 3) == 0, 1);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        i_left_reading = 0; i_right_reading = 0; i_middle_reading = 0; i_meeting_mode = 0;
        samples_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed corners with reset settings
        send_sample(0, 0, 0, 0, 0);
        send_sample(0, 0, 0, 1, 0);
        send_sample(4095, 4095, 4095, 0, 0);
        send_sample(4095, 0, 0, 0, 0);
        send_sample(0, 4095, 0, 0, 0);
        send_sample(0, 0, 4095, 0, 0);
        send_sample(0, 0, 4095, 1, 0);
        send_sample(4095, 0, 0, 1, 0);
        send_sample(100, 300, 10, 0, 0);
        send_sample(300, 100, 10, 0, 0);
        send_sample(200, 230, 10, 0, 0);
        send_sample(100, 300, 10, 1, 0);
        send_sample(2730, 1365, 2730, 0, 0);
        drain();

        // extreme gains and offsets to reach saturation
        load_settings(2047, 1000, 2047, 1000, 4095, 8190, 0, 511);
        send_sample(4095, 0, 0, 0, 0);
        send_sample(0, 0, 4095, 0, 0);
        send_sample(0, 1, 0, 0, 0);
        send_sample(1, 0, 0, 0, 0);
        send_sample(5, 5, 5, 1, 0);
        drain();
        random_phase(350);

        load_settings(12'h800, 11'h418, 12'h800, 11'h418, 0, 0, 4095, 0);
        send_sample(0, 0, 4095, 0, 0);
        send_sample(4095, 4095, 0, 0, 0);
        drain();
        random_phase(350);

        // sender holds off until everything has come back
        load_settings(256, 0, 256, 0, 500, 800, 50, 40);
        random_phase(350);
        load_settings($urandom_range(0, 4095), $urandom_range(0, 2047),
            $urandom_range(0, 4095), $urandom_range(0, 2047), $urandom_range(0, 4095),
            $urandom_range(0, 8191), $urandom_range(0, 255), $urandom_range(0, 511));
        random_phase(350);
        load_settings(-300, -1000, 600, -1000, 2000, 4000, 10, 300);
        random_phase(330);

        $display("sent %0d samples over five register settings, %0d results checked",
            samples_sent, results_seen);
        if (fail_count == 0)
            $display("inductor_steering_error_core test passed");
        else
            $display("inductor_steering_error_core test failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/isterr_pkg.sv
rtl/isterr_front.sv
rtl/isterr_fifo.sv
rtl/isterr_back.sv
rtl/inductor_steering_error_core.sv
rtl/isterr_checker.sv
verif/inductor_steering_error_checker.sv
verif/inductor_steering_error_core_test.sv
